### hdl/smtn_pkg.sv
// Shared types and constants for the sorted multiset take-neighbor block.
// No dependencies; used by smtn_ctrl, smtn_dpath and the top level.
`timescale 1ns / 1ps

package smtn_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam logic [1:0] CMD_INSERT     = 2'd0;
    localparam logic [1:0] CMD_TAKE_ABOVE = 2'd1;
    localparam logic [1:0] CMD_TAKE_ATMOST = 2'd2;

    localparam logic [1:0] ST_TAKEN    = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_CNT   = 3'd2;
    localparam logic [2:0] IDX_CNTM1 = 3'd3;
    localparam logic [2:0] IDX_INC   = 3'd4;
    localparam logic [2:0] IDX_DEC   = 3'd5;

    localparam logic [1:0] RD_IDX   = 2'd0;
    localparam logic [1:0] RD_IDXM1 = 2'd1;
    localparam logic [1:0] RD_IDXP1 = 2'd2;

    typedef struct packed {
        logic       load;
        logic [2:0] idx_op;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_key;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_set;
        logic [1:0] res_code;
        logic       take_set;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;
        logic       cnt_full;
        logic       gt;
        logic       idx_zero;
        logic       idx_last;
    } dp_stat_t;

endpackage

### hdl/smtn_dpath.sv
// Datapath: entry memory, entry count, index, compare and result registers.
// Depends on smtn_pkg; driven by smtn_ctrl.
`timescale 1ns / 1ps

module smtn_dpath #(
    parameter int CAPACITY = smtn_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  smtn_pkg::dp_cmd_t  dcmd,
    output smtn_pkg::dp_stat_t dstat,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_operand,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_taken_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];

    logic [1:0]         cmd_reg;
    logic signed [31:0] key_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg;
    logic signed [31:0] rdata_reg;
    logic [1:0]         res_reg;
    logic signed [31:0] taken_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_taken_reg;
    logic [AW-1:0]      raddr;

    always_comb begin
        case (dcmd.idx_op)
            smtn_pkg::IDX_ZERO:  idx_next = '0;
            smtn_pkg::IDX_CNT:   idx_next = AW'(cnt_reg);
            smtn_pkg::IDX_CNTM1: idx_next = AW'(cnt_reg - CW'(1));
            smtn_pkg::IDX_INC:   idx_next = idx_reg + AW'(1);
            smtn_pkg::IDX_DEC:   idx_next = idx_reg - AW'(1);
            default:             idx_next = idx_reg;
        endcase
        case (dcmd.rd_sel)
            smtn_pkg::RD_IDXM1: raddr = idx_reg - AW'(1);
            smtn_pkg::RD_IDXP1: raddr = idx_reg + AW'(1);
            default:            raddr = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dcmd.wr_en) begin
            mem[idx_reg] <= dcmd.wr_key ? key_reg : rdata_reg;
        end
        if (dcmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (dcmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CW'(1);
        end else if (dcmd.cnt_dec) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (dcmd.load) begin
            cmd_reg   <= s_cmd;
            key_reg   <= s_operand;
            taken_reg <= '0;
        end else if (dcmd.take_set) begin
            taken_reg <= rdata_reg;
        end
        if (dcmd.res_set) begin
            res_reg <= dcmd.res_code;
        end
        if (dcmd.out_load) begin
            out_status_reg <= res_reg;
            out_taken_reg  <= (res_reg == smtn_pkg::ST_TAKEN) ? taken_reg : '0;
        end
    end

    assign dstat.cmd      = cmd_reg;
    assign dstat.cnt_zero = (cnt_reg == '0);
    assign dstat.cnt_full = (cnt_reg == CW'(CAPACITY));
    assign dstat.gt       = (rdata_reg > key_reg);
    assign dstat.idx_zero = (idx_reg == '0);
    assign dstat.idx_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    assign m_status      = out_status_reg;
    assign m_taken_value = out_taken_reg;

endmodule

### hdl/smtn_ctrl.sv
// Controller FSM: sequences insert shifts, scans and removal shifts.
// Depends on smtn_pkg; commands smtn_dpath.
`timescale 1ns / 1ps

module smtn_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output smtn_pkg::dp_cmd_t  dcmd,
    input  smtn_pkg::dp_stat_t dstat
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_CMP = 4'd3;
    localparam logic [3:0] S_SC_RD   = 4'd4;
    localparam logic [3:0] S_SC_CMP  = 4'd5;
    localparam logic [3:0] S_SH_CHK  = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       above;
    logic       match;

    assign above = (dstat.cmd == smtn_pkg::CMD_TAKE_ABOVE);
    assign match = above ? dstat.gt : !dstat.gt;

    always_comb begin
        dcmd       = '0;
        dcmd.idx_op = smtn_pkg::IDX_HOLD;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dcmd.load  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                dcmd.res_set  = 1'b1;
                dcmd.res_code = smtn_pkg::ST_NONE;
                state_next    = S_OUT;
                case (dstat.cmd)
                    smtn_pkg::CMD_INSERT: begin
                        if (dstat.cnt_full) begin
                            dcmd.res_code = smtn_pkg::ST_FULL;
                        end else begin
                            dcmd.idx_op = smtn_pkg::IDX_CNT;
                            state_next  = S_INS_CHK;
                        end
                    end
                    smtn_pkg::CMD_TAKE_ABOVE: begin
                        if (!dstat.cnt_zero) begin
                            dcmd.idx_op = smtn_pkg::IDX_ZERO;
                            state_next  = S_SC_RD;
                        end
                    end
                    smtn_pkg::CMD_TAKE_ATMOST: begin
                        if (!dstat.cnt_zero) begin
                            dcmd.idx_op = smtn_pkg::IDX_CNTM1;
                            state_next  = S_SC_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_INS_CHK: begin
                if (dstat.idx_zero) begin
                    dcmd.wr_en    = 1'b1;
                    dcmd.wr_key   = 1'b1;
                    dcmd.cnt_inc  = 1'b1;
                    dcmd.res_set  = 1'b1;
                    dcmd.res_code = smtn_pkg::ST_INSERTED;
                    state_next    = S_OUT;
                end else begin
                    dcmd.rd_en  = 1'b1;
                    dcmd.rd_sel = smtn_pkg::RD_IDXM1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                dcmd.wr_en = 1'b1;
                if (dstat.gt) begin
                    // move the larger entry up one slot
                    dcmd.idx_op = smtn_pkg::IDX_DEC;
                    state_next  = S_INS_CHK;
                end else begin
                    dcmd.wr_key   = 1'b1;
                    dcmd.cnt_inc  = 1'b1;
                    dcmd.res_set  = 1'b1;
                    dcmd.res_code = smtn_pkg::ST_INSERTED;
                    state_next    = S_OUT;
                end
            end
            S_SC_RD: begin
                dcmd.rd_en  = 1'b1;
                dcmd.rd_sel = smtn_pkg::RD_IDX;
                state_next  = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (match) begin
                    dcmd.take_set = 1'b1;
                    state_next    = S_SH_CHK;
                end else if (above ? dstat.idx_last : dstat.idx_zero) begin
                    state_next = S_OUT;
                end else begin
                    dcmd.idx_op = above ? smtn_pkg::IDX_INC : smtn_pkg::IDX_DEC;
                    state_next  = S_SC_RD;
                end
            end
            S_SH_CHK: begin
                if (dstat.idx_last) begin
                    dcmd.cnt_dec  = 1'b1;
                    dcmd.res_set  = 1'b1;
                    dcmd.res_code = smtn_pkg::ST_TAKEN;
                    state_next    = S_OUT;
                end else begin
                    dcmd.rd_en  = 1'b1;
                    dcmd.rd_sel = smtn_pkg::RD_IDXP1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                dcmd.wr_en  = 1'b1;
                dcmd.idx_op = smtn_pkg::IDX_INC;
                state_next  = S_SH_CHK;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    dcmd.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (dcmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/sorted_multiset_take_neighbour.sv
// Sorted multiset with insert and take-neighbor commands.
//
// Input channel s_valid/s_ready carries s_cmd and s_operand: insert the
// operand, take the smallest value above the key, or take the largest
// value at most the key. Result channel m_valid/m_ready carries m_status
// and m_taken_value, exactly one result per item.
// One item is worked at a time. An insert moves each entry greater than
// the value up one slot and writes the value below them; a full table
// gives ST_FULL at once. A take scans for the wanted entry, ascending
// for take-above and descending for take-at-most, then moves the
// entries after the removed one down one slot; a take on an empty table,
// a take with no qualifying entry and an unused code give ST_NONE. The
// single-port entry memory does one read or write per cycle, with a
// registered read. The edge that loads the result into the output
// register also raises s_ready; a result may wait there while the next
// item is taken. If the output register is still full when the next result
// is done, the block holds until m_ready.
// Reset (aresetn low, synchronous) empties the table and drops any result.
`timescale 1ns / 1ps

module sorted_multiset_take_neighbour #(
    parameter int CAPACITY = smtn_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_operand,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_taken_value
);

    smtn_pkg::dp_cmd_t  dcmd;
    smtn_pkg::dp_stat_t dstat;

    smtn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dcmd    (dcmd),
        .dstat   (dstat)
    );

    smtn_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dcmd          (dcmd),
        .dstat         (dstat),
        .s_cmd         (s_cmd),
        .s_operand     (s_operand),
        .m_status      (m_status),
        .m_taken_value (m_taken_value)
    );

`ifndef SYNTHESIS
    a_taken_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != smtn_pkg::ST_TAKEN) |-> (m_taken_value == 32'sd0))
        else $error("taken value nonzero without take");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");

    a_wr_rd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dcmd.wr_en && dcmd.rd_en))
        else $error("memory read and write in same cycle");

    a_cnt_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dcmd.cnt_inc && dstat.cnt_full) && !(dcmd.cnt_dec && dstat.cnt_zero))
        else $error("entry count out of range");
`endif

endmodule
